/* hdl/windowed_average_peak_monitor_macros.svh */
// ----------------------------------------------------------------------------
// windowed_average_peak_monitor_macros.svh
// Assertion macros shared by the monitor RTL.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_AVERAGE_PEAK_MONITOR_MACROS_SVH
`define WINDOWED_AVERAGE_PEAK_MONITOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define WAPM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define WAPM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wapm_pkg.sv */
// ----------------------------------------------------------------------------
// wapm_pkg
// Shared widths and codes for the windowed average / peak monitor.
// ----------------------------------------------------------------------------
package wapm_pkg;

    localparam int NUM_CH     = 3;
    localparam int CH_W       = 2;
    localparam int CH_AW      = $clog2(NUM_CH);
    localparam int SAMPLE_W   = 32;
    localparam int FILL_W     = 7;
    localparam int WINDOW_DEF = 64;

    // channel code with no metric behind it
    localparam logic [CH_W-1:0] CH_NONE = 2'd3;

endpackage

/* hdl/wapm_in_if.sv */
// ----------------------------------------------------------------------------
// wapm_in_if
// Sample channel: channel number plus raw sample, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wapm_in_if import wapm_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);

endinterface

/* hdl/wapm_out_if.sv */
// ----------------------------------------------------------------------------
// wapm_out_if
// Result channel: channel, window average, peak and fill count.
// ----------------------------------------------------------------------------
interface wapm_out_if import wapm_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel_out;
    logic [SAMPLE_W-1:0] window_average;
    logic [SAMPLE_W-1:0] peak_value;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, output channel_out, output window_average,
                    output peak_value, output fill_count, input ready);
    modport sink   (input valid, input channel_out, input window_average,
                    input peak_value, input fill_count, output ready);

endinterface

/* hdl/wapm_ring_ram.sv */
// ----------------------------------------------------------------------------
// wapm_ring_ram
// Sample ring storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module wapm_ring_ram import wapm_pkg::*; #(
    parameter int DEPTH = NUM_CH * WINDOW_DEF,
    parameter int WIDTH = SAMPLE_W,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/wapm_chan_ram.sv */
// ----------------------------------------------------------------------------
// wapm_chan_ram
// Per-channel state record store; entries never written read as zero.
// ----------------------------------------------------------------------------
module wapm_chan_ram import wapm_pkg::*; #(
    parameter int DEPTH = NUM_CH,
    parameter int WIDTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

/* hdl/wapm_div.sv */
// ----------------------------------------------------------------------------
// wapm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wapm_div import wapm_pkg::*; #(
    parameter int NUM_W = SAMPLE_W + 6,
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_quot;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;
    logic [DEN_W-1:0]  n_rem;
    logic [NUM_W-1:0]  n_quot;

    // shift in next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quot[NUM_W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        n_quot  = {r_quot[NUM_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* hdl/windowed_average_peak_monitor.sv */
// ----------------------------------------------------------------------------
// windowed_average_peak_monitor
// Three-channel moving average over the last WINDOW samples with peak hold.
// ----------------------------------------------------------------------------
//
//   port    | direction | payload                                   | role
//   --------+-----------+-------------------------------------------+---------------
//   i_in    | sink      | channel, sample                           | one sample
//   o_out   | source    | channel_out, window_average, peak_value,  | one result per
//           |           | fill_count                                | sample
//
// Timing: each sample passes IDLE, RD_CH, RD_WIN, a bit-serial divide of the window
//   sum (SUM_W = 32 + clog2(WINDOW) bits) by the fill count in DIV, and EMIT.
//   Channel 3 bypasses all state: IDLE goes straight to EMIT.
// Reset: synchronous, active low; per-channel state reads as zero until first
//   written (valid bits), the sample ring needs no clearing.
// Stalls: the result sits in an output register; a new sample is accepted
//   while a previous result still waits on o_out.ready.
// ----------------------------------------------------------------------------
`include "windowed_average_peak_monitor_macros.svh"

module windowed_average_peak_monitor import wapm_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wapm_in_if.sink     i_in,
    wapm_out_if.source  o_out
);

    // ---- derived widths ----------------------------------------------------
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int SUM_W      = SAMPLE_W + SLOT_W;   // holds WINDOW full-scale samples
    localparam int ENTRY_W    = SUM_W + CNT_W + SLOT_W + SAMPLE_W;
    localparam int RING_DEPTH = NUM_CH * WINDOW;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // ---- sequencer ---------------------------------------------------------
    // IDLE  : take a sample, read its channel record
    // RD_CH : record arrives; pre-add sample, update peak, read oldest ring slot
    // RD_WIN: oldest sample arrives; finish sum, write ring and record, start divide
    // DIV   : wait for the quotient
    // EMIT  : move result into the output register once it is free
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_CH,
        S_RD_WIN,
        S_DIV,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [CH_W-1:0]     r_ch;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SUM_W-1:0]    r_sum_plus;   // old sum + new sample
    logic [CNT_W-1:0]    r_cnt;        // fill count after this sample
    logic [SLOT_W-1:0]   r_slot;
    logic [SAMPLE_W-1:0] r_peak;
    logic                r_full;
    logic [RING_AW-1:0]  r_pos;
    logic [SAMPLE_W-1:0] r_avg;

    // output register
    logic                r_out_valid;
    logic [CH_W-1:0]     r_out_ch;
    logic [SAMPLE_W-1:0] r_out_avg;
    logic [SAMPLE_W-1:0] r_out_peak;
    logic [CNT_W-1:0]    r_out_cnt;

    // ---- memory and divider hookup -----------------------------------------
    logic                w_in_accept;
    logic                w_out_free;
    logic                w_ch_re;
    logic [ENTRY_W-1:0]  w_ch_rdata;
    logic [ENTRY_W-1:0]  w_ch_wdata;
    logic                w_state_we;
    logic [SUM_W-1:0]    w_c_sum;
    logic [CNT_W-1:0]    w_c_cnt;
    logic [SLOT_W-1:0]   w_c_slot;
    logic [SAMPLE_W-1:0] w_c_peak;
    logic [RING_AW-1:0]  w_rd_pos;
    logic [SAMPLE_W-1:0] w_ring_rdata;
    logic [SUM_W-1:0]    w_new_sum;
    logic [SLOT_W-1:0]   w_next_slot;
    logic                w_div_done;
    logic [SUM_W-1:0]    w_div_quot;

    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_ch_re     = w_in_accept && (i_in.channel != CH_NONE);

    assign {w_c_sum, w_c_cnt, w_c_slot, w_c_peak} = w_ch_rdata;

    // ring address of this channel's current write slot
    assign w_rd_pos = RING_AW'(r_ch) * RING_AW'(WINDOW) + RING_AW'(w_c_slot);

    // drop the oldest sample once the window is full
    assign w_new_sum   = r_sum_plus - (r_full ? SUM_W'(w_ring_rdata) : SUM_W'(0));
    assign w_next_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
    assign w_state_we  = (r_state == S_RD_WIN);
    assign w_ch_wdata  = {w_new_sum, r_cnt, w_next_slot, r_peak};

    wapm_chan_ram #(
        .DEPTH (NUM_CH),
        .WIDTH (ENTRY_W)
    ) u_chan_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_state_we),
        .i_waddr (r_ch[CH_AW-1:0]),
        .i_wdata (w_ch_wdata),
        .i_re    (w_ch_re),
        .i_raddr (i_in.channel[CH_AW-1:0]),
        .o_rdata (w_ch_rdata)
    );

    wapm_ring_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (SAMPLE_W)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (w_state_we),
        .i_waddr (r_pos),
        .i_wdata (r_sample),
        .i_re    (r_state == S_RD_CH),
        .i_raddr (w_rd_pos),
        .o_rdata (w_ring_rdata)
    );

    wapm_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_state_we),
        .i_num   (w_new_sum),
        .i_den   (r_cnt),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // ---- control and registered outputs ------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // in EMIT the register is reloaded below instead
            if (r_out_valid && o_out.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_ch     <= i_in.channel;
                        r_sample <= i_in.sample;
                        if (i_in.channel == CH_NONE) begin
                            // unused channel: zero result, state untouched
                            r_avg   <= '0;
                            r_peak  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_RD_CH;
                        end
                    end
                end
                S_RD_CH: begin
                    r_sum_plus <= w_c_sum + SUM_W'(r_sample);
                    r_full     <= (w_c_cnt == CNT_W'(WINDOW));
                    r_cnt      <= (w_c_cnt == CNT_W'(WINDOW)) ? w_c_cnt
                                                              : w_c_cnt + CNT_W'(1);
                    r_slot     <= w_c_slot;
                    r_peak     <= (r_sample > w_c_peak) ? r_sample : w_c_peak;
                    r_pos      <= w_rd_pos;
                    r_state    <= S_RD_WIN;
                end
                S_RD_WIN: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_avg   <= SAMPLE_W'(w_div_quot);
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ch    <= r_ch;
                        r_out_avg   <= r_avg;
                        r_out_peak  <= r_peak;
                        r_out_cnt   <= r_cnt;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.channel_out    = r_out_ch;
    assign o_out.window_average = r_out_avg;
    assign o_out.peak_value     = r_out_peak;
    assign o_out.fill_count     = FILL_W'(r_out_cnt);   // count masked to port width

    // ---- assertions --------------------------------------------------------
    `WAPM_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV,
        "divider finished outside divide phase")
    `WAPM_ASSERT_NEXT(a_accept_moves_on, i_clk, i_rst_n, w_in_accept,
        r_state == S_RD_CH || r_state == S_EMIT, "accepted sample did not start processing")
    `WAPM_ASSERT_NEXT(a_emit_loads_out, i_clk, i_rst_n, r_state == S_EMIT && w_out_free,
        r_out_valid && r_state == S_IDLE, "result not moved into output register")

endmodule

/* sim/tb_windowed_average_peak_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_average_peak_monitor
// Self-checking bench for the three-channel windowed average / peak monitor.
// Each accepted sample is run through a local copy of the per-channel ring,
// running sum, fill count and peak. The outcome is queued and compared field
// by field with every result transaction. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_windowed_average_peak_monitor import wapm_pkg::*; ();

    localparam int WIN            = WINDOW_DEF;
    localparam int SUM_W          = SAMPLE_W + $clog2(WIN);
    localparam int SLOT_W         = $clog2(WIN);
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 4;
    // Longest legal quiet stretch is roughly a sender gap, one divide and
    // a long receiver stall. This limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles to watch for stray results once nothing is outstanding.
    localparam int END_SETTLE     = 120;

    // One expected result transaction
    typedef struct packed {
        logic [CH_W-1:0]     channel_out;
        logic [SAMPLE_W-1:0] window_average;
        logic [SAMPLE_W-1:0] peak_value;
        logic [FILL_W-1:0]   fill_count;
    } window_result_t;

    // Receiver behavior; switched at random
    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_CHOPPY,  // ready drops at random, decided anew at each falling edge
        RX_BURSTY   // occasional long stalls
    } rx_mode_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Testbench-owned drive values, known from time zero
    logic                tx_valid   = 1'b0;
    logic [CH_W-1:0]     tx_channel = '0;
    logic [SAMPLE_W-1:0] tx_sample  = '0;
    logic                rx_ready   = 1'b0;

    wapm_in_if  sample_bus ();
    wapm_out_if result_bus ();

    assign sample_bus.valid   = tx_valid;
    assign sample_bus.channel = tx_channel;
    assign sample_bus.sample  = tx_sample;
    assign result_bus.ready   = rx_ready;

    windowed_average_peak_monitor u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (sample_bus),
        .o_out   (result_bus)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: per-channel sample ring, running sum, fill count,
    // next write slot and peak since reset.
    // ------------------------------------------------------------------------
    logic [SAMPLE_W-1:0] ring_mem  [NUM_CH][WIN];
    logic [SUM_W-1:0]    ring_sum  [NUM_CH];
    logic [FILL_W-1:0]   ring_fill [NUM_CH];
    logic [SLOT_W-1:0]   ring_wr   [NUM_CH];
    logic [SAMPLE_W-1:0] peak_hold [NUM_CH];

    window_result_t pending_results[$];
    int             mismatch_count = 0;

    // sender burst bookkeeping
    int unsigned    burst_left = 0;

    initial begin
        for (int c = 0; c < NUM_CH; c++) begin
            ring_sum[c]  = '0;
            ring_fill[c] = '0;
            ring_wr[c]   = '0;
            peak_hold[c] = '0;
        end
    end

    // Advances the local window state by one sample and returns the result the
    // block must produce for it.
    function automatic window_result_t predict_window_result(
        input logic [CH_W-1:0]     ch,
        input logic [SAMPLE_W-1:0] s
    );
        window_result_t   r;
        logic [SUM_W-1:0] quot;
        int               c;
        int               slot;
        r = '0;
        r.channel_out = ch;
        // channel 3 has no metric: state untouched, zero payload
        if (ch >= NUM_CH)
            return r;
        c    = int'(ch);
        slot = int'(ring_wr[c]);
        // full window: retire the oldest sample before overwriting its slot
        if (ring_fill[c] >= FILL_W'(WIN))
            ring_sum[c] = ring_sum[c] - SUM_W'(ring_mem[c][slot]);
        else
            ring_fill[c] = ring_fill[c] + FILL_W'(1);
        ring_mem[c][slot] = s;
        ring_sum[c]       = ring_sum[c] + SUM_W'(s);
        ring_wr[c]        = (slot == WIN - 1) ? '0 : SLOT_W'(slot + 1);
        // strictly greater only; an equal sample keeps the held peak
        if (s > peak_hold[c])
            peak_hold[c] = s;
        quot             = ring_sum[c] / SUM_W'(ring_fill[c]);
        r.window_average = quot[SAMPLE_W-1:0];
        r.peak_value     = peak_hold[c];
        r.fill_count     = ring_fill[c];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [CH_W-1:0] pick_channel();
        // about one in twenty goes to the unused channel code
        if ($urandom_range(0, 19) == 19)
            return CH_NONE;
        return CH_W'($urandom_range(0, NUM_CH - 1));
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [CH_W-1:0] ch);
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 6))
            0: v = SAMPLE_W'($urandom_range(0, 255));
            1: v = 32'hFFFF_FFFF - SAMPLE_W'($urandom_range(0, 255));
            2: v = (ch < NUM_CH) ? peak_hold[ch] : SAMPLE_W'($urandom);
            3: v = 32'h1 << $urandom_range(0, SAMPLE_W - 1);
            // typical 24.8 style fixed-point load / latency figures
            4: v = SAMPLE_W'(($urandom_range(0, 1000) << 8) | $urandom_range(0, 255));
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    // Entry and exit at a falling edge. Valid stays up across a burst; between
    // bursts it drops for a random gap (sometimes none).
    task automatic send_sample(
        input logic [CH_W-1:0]     ch,
        input logic [SAMPLE_W-1:0] s
    );
        tx_channel = ch;
        tx_sample  = s;
        tx_valid   = 1'b1;
        @(posedge clk);
        while (!sample_bus.ready) @(posedge clk);
        pending_results = {pending_results, predict_window_result(ch, s)};
        @(negedge clk);
        if (burst_left == 0) begin
            tx_valid   = 1'b0;
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 50)) @(negedge clk);
        end else begin
            burst_left--;
        end
    endtask

    // Holds the sender off until every queued result has been checked.
    task automatic wait_results_drained();
        tx_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // Field extremes, every channel code, the equal-to-peak rule and the
    // unused channel.
    task automatic test_directed_corners();
        send_sample(2'd0, 32'h0000_0000);  // first sample equals reset peak
        send_sample(2'd0, 32'hFFFF_FFFF);
        send_sample(2'd0, 32'hFFFF_FFFF);  // equal to peak
        send_sample(2'd0, 32'h0000_0001);
        send_sample(2'd1, 32'hFFFF_FFFF);
        send_sample(2'd1, 32'h0000_0000);
        send_sample(2'd1, 32'hAAAA_AAAA);
        send_sample(2'd1, 32'h5555_5555);
        send_sample(2'd2, 32'h0000_0100);  // 1.0 ms
        send_sample(2'd2, 32'h7FFF_FFFF);
        send_sample(2'd2, 32'h8000_0000);
        send_sample(2'd2, 32'h8000_0000);  // equal to peak
        send_sample(CH_NONE, 32'hFFFF_FFFF);
        send_sample(CH_NONE, 32'h0000_0000);
        send_sample(2'd0, 32'h0000_6400);  // 100.0 percent
        send_sample(CH_NONE, 32'h1234_5678);
    endtask

    // Randomly mixed channels with varied sample shapes.
    task automatic test_random_channels(input int n);
        logic [CH_W-1:0] ch;
        for (int i = 0; i < n; i++) begin
            ch = pick_channel();
            send_sample(ch, pick_sample(ch));
        end
    endtask

    // Long runs of near full-scale values, mostly on one channel: wraps the ring
    // and drives the running sum close to its top bit.
    task automatic test_window_wrap_extremes(input int runs);
        logic [CH_W-1:0] ch;
        logic [CH_W-1:0] other;
        for (int r = 0; r < runs; r++) begin
            ch = CH_W'($urandom_range(0, NUM_CH - 1));
            for (int i = 0; i < WIN + 12; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    other = pick_channel();
                    send_sample(other, pick_sample(other));
                end else if ($urandom_range(0, 7) == 0) begin
                    send_sample(ch, 32'hFFFF_FFFF);
                end else begin
                    send_sample(ch, 32'hFFFF_FFFF - SAMPLE_W'($urandom_range(0, 4095)));
                end
            end
        end
    endtask

    // Sender stops until the result side is empty, then resumes.
    task automatic test_drain_then_resume();
        test_random_channels(20);
        wait_results_drained();
        test_random_channels(20);
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall pattern, independent of the sender
    // ------------------------------------------------------------------------
    rx_mode_e    rx_mode       = RX_OPEN;
    int unsigned rx_mode_left  = 0;
    int unsigned rx_stall_left = 0;

    always @(negedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_e'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(100, 400);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_OPEN: begin
                rx_ready = 1'b1;
            end
            RX_CHOPPY: begin
                rx_ready = ($urandom_range(0, 2) != 0);
            end
            default: begin
                if (rx_stall_left != 0) begin
                    rx_stall_left--;
                    rx_ready = 1'b0;
                end else begin
                    rx_ready = 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        rx_stall_left = $urandom_range(10, 70);
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Result checker: every result transaction against the oldest prediction
    // ------------------------------------------------------------------------
    window_result_t want;

    always @(posedge clk) begin
        if (rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing outstanding: channel_out %0d",
                       result_bus.channel_out);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (result_bus.channel_out !== want.channel_out) begin
                    $error("channel_out: expected %0d, got %0d",
                           want.channel_out, result_bus.channel_out);
                    mismatch_count++;
                end
                if (result_bus.window_average !== want.window_average) begin
                    $error("window_average: expected 0x%08h, got 0x%08h",
                           want.window_average, result_bus.window_average);
                    mismatch_count++;
                end
                if (result_bus.peak_value !== want.peak_value) begin
                    $error("peak_value: expected 0x%08h, got 0x%08h",
                           want.peak_value, result_bus.peak_value);
                    mismatch_count++;
                end
                if (result_bus.fill_count !== want.fill_count) begin
                    $error("fill_count: expected %0d, got %0d",
                           want.fill_count, result_bus.fill_count);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run after too many cycles with no transaction on
    // either side
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (sample_bus.valid && sample_bus.ready) ||
            (result_bus.valid && result_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_corners();
        test_random_channels(250);
        test_drain_then_resume();
        test_window_wrap_extremes(2);
        test_random_channels(200);

        // let everything land, then watch for stray results
        wait_results_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
